@@ rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Capacity, widths, command codes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int OUT_W    = 1 + POS_W + COUNT_W;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SRCH,
    ST_INS,
    ST_DEL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  at;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic load;
  } cell_stat_t;

endpackage

@@ rtl/sle_cell.sv @@
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one key and its compare flags; shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                      clk,
  input  sle_pkg::cell_ctl_t        ctl,
  input  logic [sle_pkg::IDX_W-1:0] idx,
  input  logic [sle_pkg::KEY_W-1:0] left_entry,
  input  logic                      left_go,
  input  logic [sle_pkg::KEY_W-1:0] right_entry,
  output logic [sle_pkg::KEY_W-1:0] entry,
  output logic                      go,
  output sle_pkg::cell_stat_t       stat
);
  import sle_pkg::*;

  logic [KEY_W-1:0] entry_r, entry_nxt;
  logic             gt_r, gt_nxt;
  logic             eq_r, eq_nxt;
  logic             occ;
  logic             load;

  // slot holds a live key
  assign occ  = CNT_W'(idx) < ctl.count;
  // live key larger than the new one: moves up on insert
  assign go   = occ & gt_r;
  // first slot that is empty or larger, with the left one staying put
  assign load = !left_go && (go || (CNT_W'(idx) == ctl.count));

  always_comb begin
    entry_nxt = entry_r;
    gt_nxt    = gt_r;
    eq_nxt    = eq_r;
    case (ctl.op)
      CELL_CMP: begin
        gt_nxt = $signed(entry_r) > $signed(ctl.key);
        eq_nxt = entry_r == ctl.key;
      end
      CELL_INS: begin
        if (left_go) begin
          entry_nxt = left_entry;
        end else if (load) begin
          entry_nxt = ctl.key;
        end
      end
      CELL_DEL: begin
        if (idx >= ctl.at) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    gt_r    <= gt_nxt;
    eq_r    <= eq_nxt;
  end

  assign entry     = entry_r;
  assign stat.gt   = gt_r;
  assign stat.eq   = eq_r;
  assign stat.load = load;

endmodule

@@ rtl/sorted_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine_unit: bounded sorted list of signed keys
// A row of key cells with a small sequencer for insert, delete, search, clear.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+------------
//  in_      | slave     | key[31:0]                      | cmd[1:0]
//  out_     | master    | ok[0] position[6:1] count[13:7]| -
//
//  sequence: every word passes a compare step; clear ends there, an insert adds an
//    insert step unless the list is full, search and delete run the halving search,
//    which walks the registered compare flags one step per cycle, and a delete hit
//    adds a shift step
//  reset: rst_n low clears the sequencer, the fill count and the output
//    valid; key cells are not cleared, slots above the count are never read
//  stalls: a finished result waits in the sequencer while the output
//    register is still full; the next word is taken once the result moves
//
module sorted_list_engine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sle_pkg::KEY_W-1:0]    in_tdata,   // key
  input  logic [sle_pkg::CMD_W-1:0]    in_tuser,   // cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sle_pkg::OUT_TW-1:0]   out_tdata   // ok, position, count, zero pad
);
  import sle_pkg::*;

  state_t state_r, state_nxt;

  // command word held while it is worked on
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;

  // list occupancy
  logic [CNT_W-1:0] fill_r;

  // halving search bounds, upper bound exclusive
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [IDX_W-1:0] at_r;

  // result under construction
  logic             ok_r;
  logic [IDX_W-1:0] pos_r;

  // output register
  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;

  // cell row
  cell_ctl_t        ctl;
  logic [KEY_W-1:0] entry_w [CAPACITY];
  logic             go_w    [CAPACITY];
  cell_stat_t       stat_w  [CAPACITY];
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] load_vec;

  logic             in_fire;
  logic             out_free;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             srch_live;
  logic             srch_hit;
  logic             list_full;
  logic [IDX_W-1:0] ins_pos;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign list_full = fill_r == CNT_W'(CAPACITY);

  // midpoint rounded down over [lo, hi)
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid       = mid_sum[IDX_W:1];
  assign srch_live = lo_r < hi_r;
  assign srch_hit  = srch_live && eq_vec[mid];

  // ------------------------------------------------------------------ cells
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_W-1:0] left_entry;
      logic             left_go;
      logic [KEY_W-1:0] right_entry;

      if (g == 0) begin : g_first
        assign left_entry = '0;
        assign left_go    = 1'b0;
      end else begin : g_mid
        assign left_entry = entry_w[g-1];
        assign left_go    = go_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = entry_w[g+1];
      end

      sle_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .idx         (IDX_W'(g)),
        .left_entry  (left_entry),
        .left_go     (left_go),
        .right_entry (right_entry),
        .entry       (entry_w[g]),
        .go          (go_w[g]),
        .stat        (stat_w[g])
      );

      assign gt_vec[g]   = stat_w[g].gt;
      assign eq_vec[g]   = stat_w[g].eq;
      assign load_vec[g] = stat_w[g].load;
    end
  endgenerate

  // insert slot as a binary index (exactly one cell loads)
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (load_vec[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  // ------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        case (cmd_r)
          CMD_INSERT: state_nxt = list_full ? ST_DONE : ST_INS;
          CMD_DELETE,
          CMD_SEARCH: state_nxt = ST_SRCH;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_SRCH: begin
        if (!srch_live) begin
          state_nxt = ST_DONE;
        end else if (srch_hit) begin
          state_nxt = (cmd_r == CMD_DELETE) ? ST_DEL : ST_DONE;
        end
      end
      ST_INS,
      ST_DEL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_tready = 1'b0;
    ctl.op    = CELL_HOLD;
    ctl.key   = key_r;
    ctl.at    = at_r;
    ctl.count = fill_r;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CMP:  ctl.op    = CELL_CMP;
      ST_INS:  ctl.op    = CELL_INS;
      ST_DEL:  ctl.op    = CELL_DEL;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CMP: begin
          if (cmd_r == CMD_CLEAR) begin
            fill_r <= '0;
          end
        end
        ST_INS:  fill_r <= fill_r + CNT_W'(1);
        ST_DEL:  fill_r <= fill_r - CNT_W'(1);
        default: begin
        end
      endcase
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_r <= cmd_t'(in_tuser);
          key_r <= in_tdata;
        end
      end
      ST_CMP: begin
        lo_r  <= '0;
        hi_r  <= fill_r;
        ok_r  <= (cmd_r == CMD_CLEAR);
        pos_r <= '0;
      end
      ST_SRCH: begin
        if (srch_hit) begin
          at_r  <= mid;
          ok_r  <= 1'b1;
          pos_r <= mid;
        end else if (srch_live) begin
          // entry below the key: search the upper half
          if (!gt_vec[mid]) begin
            lo_r <= CNT_W'(mid) + CNT_W'(1);
          end else begin
            hi_r <= CNT_W'(mid);
          end
        end
      end
      ST_INS: begin
        ok_r  <= 1'b1;
        pos_r <= ins_pos;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= OUT_TW'({fill_r[COUNT_W-1:0], POS_W'(pos_r), ok_r});
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ------------------------------------------------------------- assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS |-> $onehot(load_vec))
    else $error("insert slot not unique");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DEL |=> fill_r == $past(fill_r) - CNT_W'(1))
    else $error("delete did not drop the count by one");

  a_srch_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> (lo_r <= hi_r) && (hi_r <= fill_r))
    else $error("search bounds out of order");

endmodule

@@ verif/sorted_list_engine_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_unit_checker: shadow list and result scoreboard
// Watches both streams, keeps its own sorted copy of the list, predicts the
// result word of every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [sle_pkg::KEY_W-1:0]    in_tdata,   // key
  input  logic [sle_pkg::CMD_W-1:0]    in_tuser,   // cmd
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [sle_pkg::OUT_TW-1:0]   out_tdata,  // ok, position, count, zero pad
  output int                           mismatch_count,
  output int                           pending_results
);
  import sle_pkg::*;

  // packed from the top down, so ok lands in bit 0 as on the bus
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   position;
    logic               ok;
  } list_result_t;

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int unsigned             shadow_count = 0;
  list_result_t            awaited_results [$];
  int                      failures = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  // halving search over the held keys, midpoint rounded down
  function automatic bit locate_key(input logic signed [KEY_W-1:0] key,
                                    output int unsigned where);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo    = 0;
    hi    = shadow_count;
    where = 0;
    while (lo < hi) begin
      mid = (lo + hi - 1) / 2;
      if (shadow_keys[mid] == key) begin
        where = mid;
        return 1'b1;
      end
      if (shadow_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  function automatic list_result_t apply_command(input cmd_t op,
                                                 input logic signed [KEY_W-1:0] key);
    list_result_t res;
    int unsigned  slot;
    res = '0;
    case (op)
      CMD_INSERT: begin
        if (shadow_count < CAPACITY) begin
          // equal keys stay in front of the new one
          slot = shadow_count;
          while (slot > 0 && shadow_keys[slot-1] > key) begin
            shadow_keys[slot] = shadow_keys[slot-1];
            slot--;
          end
          shadow_keys[slot] = key;
          shadow_count++;
          res.ok       = 1'b1;
          res.position = POS_W'(slot);
        end
      end
      CMD_DELETE: begin
        if (locate_key(key, slot)) begin
          for (int unsigned i = slot; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          res.ok       = 1'b1;
          res.position = POS_W'(slot);
        end
      end
      CMD_SEARCH: begin
        if (locate_key(key, slot)) begin
          res.ok       = 1'b1;
          res.position = POS_W'(slot);
        end
      end
      default: begin
        shadow_count = 0;
        res.ok       = 1'b1;
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      // a result can never belong to a command taken at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_W-1:0];
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing outstanding (%h)", out_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
          if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, want.position));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_command(cmd_t'(in_tuser), $signed(in_tdata)));
    end
    mismatch_count  <= failures;
    pending_results <= awaited_results.size();
  end

endmodule

@@ verif/sorted_list_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_unit_tb: command stream test of the sorted list engine
// Directed words over the key extremes, duplicates and misses, then random
// phases that fill, search, shrink and clear the list under random idling and
// one long output hold-off. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int IDLE_PCT     = 7;       // chance of an idle cycle on either side
  localparam int RANDOM_WORDS = 440;
  localparam int POOL_SIZE    = 12;
  localparam int HOLD_CYCLES  = 400;     // length of the long output hold-off
  localparam int DRAIN_CYCLES = 32;      // settle time once nothing is outstanding
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [KEY_W-1:0]     in_tdata   = '0;
  logic [CMD_W-1:0]     in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_TW-1:0]    out_tdata;

  int                   mismatch_count;
  int                   pending_results;
  int                   words_sent = 0;
  bit                   quiet      = 1'b0;  // no idling on either side while set
  logic                 rx_hold    = 1'b0;  // receiver holds off while set
  logic [KEY_W-1:0]     key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  sorted_list_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sorted_list_engine_unit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // receiver: random stalls, none during the quiet stretch, held off completely in hold-off
  always @(posedge clk)
    out_tready <= !rx_hold && (quiet || $urandom_range(99) >= IDLE_PCT);

  // long hold-off: the sender keeps offering words until the block backs up
  initial begin
    wait (words_sent >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // one command word; valid stays high across back-to-back words
  task automatic send_word(input cmd_t op, input logic [KEY_W-1:0] key);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    quiet = (words_sent >= 300 && words_sent < 400);
  endtask

  // mostly keys from the phase pool so that hits and duplicates are common
  function automatic logic [KEY_W-1:0] pool_key();
    if ($urandom_range(4) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  initial begin
    int          stop_at;
    int          n;
    int          pick;
    logic [31:0] base;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_word(CMD_CLEAR,  32'hDEAD_BEEF);   // key ignored by clear
    send_word(CMD_SEARCH, 32'd5);           // miss on an empty list
    send_word(CMD_DELETE, 32'd5);           // miss on an empty list
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_INSERT, 32'h8000_0000);   // most negative key goes first
    send_word(CMD_INSERT, 32'h7FFF_FFFF);   // most positive key goes last
    send_word(CMD_INSERT, 32'hFFFF_FFFF);   // -1 sorts below zero
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd5);           // duplicates land after the equal ones
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_SEARCH, 32'd5);
    send_word(CMD_SEARCH, 32'h8000_0000);
    send_word(CMD_SEARCH, 32'h7FFF_FFFF);
    send_word(CMD_SEARCH, 32'd7);           // miss between held keys
    send_word(CMD_DELETE, 32'd5);
    send_word(CMD_DELETE, 32'h8000_0000);
    send_word(CMD_DELETE, 32'h7FFF_FFFF);
    send_word(CMD_DELETE, 32'd7);
    send_word(CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 32'h5555_5555);
    send_word(CMD_INSERT, 32'hAAAA_AAAA);
    send_word(CMD_CLEAR,  32'd0);
    send_word(CMD_SEARCH, 32'd0);           // miss after clear

    // ---- random phases ----
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      // fresh key pool per phase: wide keys, small keys, extremes, repeats
      for (int k = 0; k < POOL_SIZE; k++) begin
        case ($urandom_range(3))
          0:       key_pool[k] = $urandom;
          1:       key_pool[k] = 32'($urandom_range(20)) - 32'd10;
          2:       key_pool[k] = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(2)
                                                   : 32'h7FFF_FFFF - $urandom_range(2);
          default: key_pool[k] = (k == 0) ? $urandom : key_pool[0];
        endcase
      end

      if ($urandom_range(3) == 0) begin
        // fill phase: clear, then insert up to or past capacity, often hitting the full list
        send_word(CMD_CLEAR, $urandom);
        base = $urandom_range(1) ? 32'($urandom_range(1000)) : $urandom;
        n    = $urandom_range(62, 72);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1)) send_word(CMD_INSERT, pool_key());
          else send_word(CMD_INSERT, base + 32'(i * 3));  // rising run
        end
        repeat ($urandom_range(4, 10)) begin
          if ($urandom_range(1)) send_word(CMD_SEARCH, pool_key());
          else send_word(CMD_DELETE, pool_key());
        end
      end else begin
        // mixed phase, biased towards growth
        repeat ($urandom_range(30, 60)) begin
          pick = $urandom_range(99);
          if (pick < 40) send_word(CMD_INSERT, pool_key());
          else if (pick < 70) send_word(CMD_SEARCH, pool_key());
          else if (pick < 96) send_word(CMD_DELETE, pool_key());
          else send_word(CMD_CLEAR, $urandom);
        end
      end
    end

    // ---- drain ----
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
